>>> design/rcbp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcbp_pkg
// Shared byte codes, sizes and the classified word type of the byte parser.
// ---------------------------------------------------------------------------
package rcbp_pkg;

   localparam int FRAME_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [7:0] BYTE_TURN_ON   = 8'h4B;
   localparam logic [7:0] BYTE_TURN_OFF1 = 8'h49;
   localparam logic [7:0] BYTE_TURN_OFF2 = 8'h4A;
   localparam logic [7:0] BYTE_OPEN      = 8'h7B;
   localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
   localparam logic [7:0] BYTE_REPORT    = 8'h50;
   localparam logic [7:0] BYTE_SAVE      = 8'h57;
   localparam logic [7:0] BYTE_HASH      = 8'h23;
   localparam logic [7:0] BYTE_RIGHT     = 8'h43;
   localparam logic [7:0] BYTE_LEFT      = 8'h47;
   localparam logic [7:0] BYTE_DIGIT0    = 8'h30;
   localparam logic [7:0] BYTE_SEL_LAST  = 8'h36;
   localparam logic [7:0] BYTE_DIR_FIRST = 8'h41;
   localparam logic [7:0] BYTE_DIR_LAST  = 8'h48;
   localparam logic [7:0] BYTE_DIR_FIVE  = 8'h45;
   localparam logic [7:0] BYTE_RAW_LAST  = 8'h08;

   typedef struct packed {
      logic              open_hit;
      logic              close_hit;
      logic              turn_set;
      logic              turn_clear;
      logic              left_hit;
      logic              right_hit;
      logic [3:0]        dir_plain;
      logic [3:0]        dir_turn;
      logic signed [8:0] digit;
      logic [7:0]        raw;
   } cls_type;

endpackage
`default_nettype wire

>>> design/rcbp_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcbp_front
// Accepts received bytes and classifies each one into a decoded word.
// ---------------------------------------------------------------------------
module rcbp_front
   import rcbp_pkg::*;
(
   input  wire logic       req_valid,
   input  wire logic [7:0] req_rx_byte,
   output logic            req_stall,
   input  wire logic       queue_full,
   output logic            push,
   output cls_type         push_data
);

   logic [7:0] b;

   assign b         = req_rx_byte;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data            = '0;
      push_data.raw        = b;
      push_data.open_hit   = (b == BYTE_OPEN);
      push_data.close_hit  = (b == BYTE_CLOSE);
      push_data.turn_set   = (b == BYTE_TURN_ON);
      push_data.turn_clear = (b == BYTE_TURN_OFF1) || (b == BYTE_TURN_OFF2);
      push_data.left_hit   = (b == BYTE_LEFT);
      push_data.right_hit  = (b == BYTE_RIGHT);
      push_data.digit      = $signed({1'b0, b}) - $signed({1'b0, BYTE_DIGIT0});
      if ((b >= BYTE_DIR_FIRST && b <= BYTE_DIR_LAST) || b <= BYTE_RAW_LAST) begin
         push_data.dir_plain = b[3:0];
      end else begin
         push_data.dir_plain = 4'd0;
      end
      if (b == BYTE_DIR_FIRST || b == BYTE_DIR_FIVE) begin
         push_data.dir_turn = b[3:0];
      end else begin
         push_data.dir_turn = 4'd0;
      end
   end

endmodule
`default_nettype wire

>>> design/rcbp_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcbp_queue
// Short first-in first-out queue of classified words between the two halves.
// ---------------------------------------------------------------------------
module rcbp_queue
   import rcbp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cls_type   push_data,
   input  wire logic pop,
   output logic      full,
   output logic      not_empty,
   output cls_type   head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cls_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> design/rcbp_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rcbp_back
// Carries out classified words: turn and direction state, frame collection,
// decimal accumulation and the registered result word.
// ---------------------------------------------------------------------------
module rcbp_back
   import rcbp_pkg::*;
#(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        queue_not_empty,
   input  cls_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_direction,
   output logic             rsp_turn_mode,
   output logic             rsp_turn_left,
   output logic             rsp_turn_right,
   output logic             rsp_param_write,
   output logic [2:0]       rsp_param_select,
   output logic signed [31:0] rsp_param_value,
   output logic             rsp_report_request,
   output logic             rsp_save_request
);

   localparam int CW = $clog2(FRAME_DEPTH + 1);
   localparam logic signed [35:0] ACC_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] ACC_MIN = 36'shF_8000_0000;

   logic                pos_mode_ff;
   logic                turn_ff, turn_in;
   logic [3:0]          dir_ff, dir_in;
   logic                left_ff, left_in;
   logic                right_ff, right_in;
   logic                coll_ff, coll_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [7:0]          sel_ff, sel_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic signed [31:0]  acc_ff, acc_in;

   logic                out_valid_ff;
   logic [3:0]          out_dir_ff;
   logic                out_turn_ff, out_left_ff, out_right_ff;
   logic                out_pw_ff, out_pw_in;
   logic [2:0]          out_psel_ff, out_psel_in;
   logic signed [31:0]  out_pval_ff, out_pval_in;
   logic                out_rep_ff, out_rep_in;
   logic                out_sav_ff, out_sav_in;

   logic signed [35:0]  acc_ext, acc_prod, acc_sum;
   logic signed [31:0]  acc_sat;
   logic                coll_now;

   assign pop = queue_not_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      acc_ext  = 36'(acc_ff);
      acc_prod = (acc_ext <<< 3) + (acc_ext <<< 1);
      acc_sum  = acc_prod + 36'(head.digit);
      priority if (acc_sum > ACC_MAX) begin
         acc_sat = ACC_MAX[31:0];
      end else if (acc_sum < ACC_MIN) begin
         acc_sat = ACC_MIN[31:0];
      end else begin
         acc_sat = acc_sum[31:0];
      end
   end

   always_comb begin
      turn_in     = turn_ff;
      dir_in      = dir_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      coll_in     = coll_ff;
      count_in    = count_ff;
      sel_in      = sel_ff;
      cmd_in      = cmd_ff;
      acc_in      = acc_ff;
      out_pw_in   = 1'b0;
      out_psel_in = 3'd0;
      out_pval_in = '0;
      out_rep_in  = 1'b0;
      out_sav_in  = 1'b0;
      coll_now    = coll_ff || head.open_hit;

      priority if (head.turn_set) begin
         turn_in = 1'b1;
      end else if (head.turn_clear) begin
         turn_in = 1'b0;
      end else begin
         turn_in = turn_ff;
      end

      if (!pos_mode_ff) begin
         if (!turn_in) begin
            dir_in = head.dir_plain;
         end else begin
            dir_in   = head.dir_turn;
            left_in  = head.left_hit;
            right_in = head.right_hit;
         end
      end

      priority if (head.close_hit) begin
         priority if (cmd_ff == BYTE_REPORT) begin
            out_rep_in = 1'b1;
         end else if (cmd_ff == BYTE_SAVE) begin
            out_sav_in = 1'b1;
         end else if (sel_ff != BYTE_HASH && sel_ff >= BYTE_DIGIT0 &&
                      sel_ff <= BYTE_SEL_LAST) begin
            out_pw_in   = 1'b1;
            out_psel_in = sel_ff[2:0];
            out_pval_in = acc_ff;
         end else begin
            out_pw_in = 1'b0;
         end
         coll_in  = 1'b0;
         count_in = '0;
         sel_in   = '0;
         cmd_in   = '0;
         acc_in   = '0;
      end else if (coll_now) begin
         coll_in = 1'b1;
         if (count_ff < CW'(FRAME_DEPTH)) begin
            if (count_ff == CW'(1)) begin
               sel_in = head.raw;
            end
            if (count_ff == CW'(3)) begin
               cmd_in = head.raw;
            end
            if (count_ff >= CW'(3)) begin
               acc_in = acc_sat;
            end
            count_in = count_ff + CW'(1);
         end
      end else begin
         coll_in = coll_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_mode_ff  <= 1'b0;
         turn_ff      <= 1'b0;
         dir_ff       <= '0;
         left_ff      <= 1'b0;
         right_ff     <= 1'b0;
         coll_ff      <= 1'b0;
         count_ff     <= '0;
         sel_ff       <= '0;
         cmd_ff       <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pos_mode_ff <= csr_write_data;
         end
         if (pop) begin
            turn_ff  <= turn_in;
            dir_ff   <= dir_in;
            left_ff  <= left_in;
            right_ff <= right_in;
            coll_ff  <= coll_in;
            count_ff <= count_in;
            sel_ff   <= sel_in;
            cmd_ff   <= cmd_in;
            acc_ff   <= acc_in;
         end
         if (pop) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_dir_ff   <= dir_in;
         out_turn_ff  <= turn_in;
         out_left_ff  <= left_in;
         out_right_ff <= right_in;
         out_pw_ff    <= out_pw_in;
         out_psel_ff  <= out_psel_in;
         out_pval_ff  <= out_pval_in;
         out_rep_ff   <= out_rep_in;
         out_sav_ff   <= out_sav_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_direction      = out_dir_ff;
   assign rsp_turn_mode      = out_turn_ff;
   assign rsp_turn_left      = out_left_ff;
   assign rsp_turn_right     = out_right_ff;
   assign rsp_param_write    = out_pw_ff;
   assign rsp_param_select   = out_psel_ff;
   assign rsp_param_value    = out_pval_ff;
   assign rsp_report_request = out_rep_ff;
   assign rsp_save_request   = out_sav_ff;

endmodule
`default_nettype wire

>>> design/remote_command_byte_parser.sv
`default_nettype none
// Flow: an accepted word is written into the queue and then popped by the back
// half, which registers its result word; a result stall holds it in the queue.
// Throughput: one word per cycle while the queue is not full and the result is
// not stalled; a four-word queue lets either side stall on its own.
// Reset: synchronous reset clears the parser state, the result valid flag, the
// queue pointers and the mode register at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// remote_command_byte_parser
// Remote-control byte parser: a classifying front half, a short queue and an
// executing back half that keeps turn, direction and frame state.
// ---------------------------------------------------------------------------
module remote_command_byte_parser
   import rcbp_pkg::*;
#(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire logic          csr_write_data,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [3:0]         rsp_direction,
   output logic               rsp_turn_mode,
   output logic               rsp_turn_left,
   output logic               rsp_turn_right,
   output logic               rsp_param_write,
   output logic [2:0]         rsp_param_select,
   output logic signed [31:0] rsp_param_value,
   output logic               rsp_report_request,
   output logic               rsp_save_request
);

   logic    queue_full;
   logic    queue_not_empty;
   logic    push;
   logic    pop;
   cls_type push_data;
   cls_type head;

   rcbp_front u_front (
      .req_valid  (req_valid),
      .req_rx_byte(req_rx_byte),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   rcbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .full     (queue_full),
      .not_empty(queue_not_empty),
      .head     (head)
   );

   rcbp_back #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .queue_not_empty   (queue_not_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_direction     (rsp_direction),
      .rsp_turn_mode     (rsp_turn_mode),
      .rsp_turn_left     (rsp_turn_left),
      .rsp_turn_right    (rsp_turn_right),
      .rsp_param_write   (rsp_param_write),
      .rsp_param_select  (rsp_param_select),
      .rsp_param_value   (rsp_param_value),
      .rsp_report_request(rsp_report_request),
      .rsp_save_request  (rsp_save_request)
   );

endmodule
`default_nettype wire
